>>> hdl/rhc_pkg.sv
// shared types, constants and divider step function for the rgb/hsv converter
package rhc_pkg;

  localparam int ChanW = 8;
  localparam int NumW = 2 * ChanW;
  localparam int QuoW = ChanW;
  localparam int QuoIdxW = $clog2(QuoW);
  localparam int BitsPerStep = 2;
  localparam int DivStages = QuoW / BitsPerStep;
  localparam int FrontStages = 3;
  localparam int Stages = FrontStages + DivStages + 1;

  localparam logic [ChanW-1:0] HueSpan = 8'd43;
  localparam logic [ChanW-1:0] HueBaseRed = 8'd0;
  localparam logic [ChanW-1:0] HueBaseGreen = 8'd85;
  localparam logic [ChanW-1:0] HueBaseBlue = 8'd171;
  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  localparam logic [2:0] Sector0 = 3'd0;
  localparam logic [2:0] Sector1 = 3'd1;
  localparam logic [2:0] Sector2 = 3'd2;
  localparam logic [2:0] Sector3 = 3'd3;
  localparam logic [2:0] Sector4 = 3'd4;
  localparam logic [2:0] Sector5 = 3'd5;

  localparam logic DirHsvToRgb = 1'b0;
  localparam logic DirRgbToHsv = 1'b1;

  typedef struct packed {
    logic [ChanW-1:0] comp_first;
    logic [ChanW-1:0] comp_second;
    logic [ChanW-1:0] comp_third;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] res_first;
    logic [ChanW-1:0] res_second;
    logic [ChanW-1:0] res_third;
  } pix_out_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [NumW:0] rhc_div_step(logic [NumW-1:0] rem,
                                                 logic [ChanW-1:0] den,
                                                 logic [QuoIdxW-1:0] sh);
    logic [NumW-1:0] dsh;
    dsh = NumW'(den) << sh;
    if (rem >= dsh) begin
      return {1'b1, rem - dsh};
    end else begin
      return {1'b0, rem};
    end
  endfunction

endpackage

>>> hdl/rhc_divider.sv
// pipelined restoring divider, two quotient bits per stage
module rhc_divider (
  input  logic                                 clk_i,
  input  logic [rhc_pkg::DivStages-1:0]        en_i,
  input  logic [rhc_pkg::NumW-1:0]             num_i,
  input  logic [rhc_pkg::ChanW-1:0]            den_i,
  output logic [rhc_pkg::QuoW-1:0]             quo_o
);
  import rhc_pkg::*;

  logic [NumW-1:0]  rem_q [DivStages];
  logic [ChanW-1:0] den_q [DivStages];
  logic [QuoW-1:0]  quo_q [DivStages];

  logic [NumW-1:0]  rem_in [DivStages];
  logic [ChanW-1:0] den_in [DivStages];
  logic [QuoW-1:0]  quo_in [DivStages];

  for (genvar j = 0; j < DivStages; j++) begin : g_stage
    localparam int HiBit = QuoW - 1 - BitsPerStep * j;

    logic [NumW-1:0] rem_d;
    logic [QuoW-1:0] quo_d;
    logic [NumW:0]   step_c;

    if (j == 0) begin : g_first
      assign rem_in[j] = num_i;
      assign den_in[j] = den_i;
      assign quo_in[j] = '0;
    end else begin : g_next
      assign rem_in[j] = rem_q[j-1];
      assign den_in[j] = den_q[j-1];
      assign quo_in[j] = quo_q[j-1];
    end

    always_comb begin
      rem_d  = rem_in[j];
      quo_d  = quo_in[j];
      step_c = '0;
      for (int b = 0; b < BitsPerStep; b++) begin
        step_c = rhc_div_step(rem_d, den_in[j], QuoIdxW'(HiBit - b));
        quo_d[QuoIdxW'(HiBit - b)] = step_c[NumW];
        rem_d = step_c[NumW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= rem_d;
        den_q[j] <= den_in[j];
        quo_q[j] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

>>> hdl/rgb_hsv_color_converter_unit.sv
// top level of the rgb/hsv pixel converter
// Converts one 8-bit-per-channel pixel per item, HSV to RGB when the direction
// register is 0 and RGB to HSV when it is 1. The unit takes a new item every
// clock while in_stall_o is low and passes each result through an input register,
// two stages that form the hue sector, max/min and the first 8x8 products, four
// divider stages that each retire two quotient bits of the saturation and hue
// quotients, and an output register. A stall holds each full stage that has no
// empty stage after it, and empty stages fill while the output is stalled.
module rgb_hsv_color_converter_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rhc_pkg::pix_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rhc_pkg::pix_out_t out_data_o
);
  import rhc_pkg::*;

  typedef struct packed {
    logic             dir;
    pix_in_t          pix;
  } s1_t;

  typedef struct packed {
    logic             dir;
    logic             zero_sat;
    logic [ChanW-1:0] v;
    logic [ChanW-1:0] s;
    logic [2:0]       region;
    logic [ChanW-1:0] rem6;
    logic             black;
    logic             gray;
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] base;
    logic             neg;
    logic [ChanW-1:0] mag;
    logic [ChanW-1:0] d;
  } s2_t;

  typedef struct packed {
    logic             dir;
    logic             zero_sat;
    logic [ChanW-1:0] v;
    logic [2:0]       region;
    logic [ChanW-1:0] p;
    logic [ChanW-1:0] sr_hi;
    logic [ChanW-1:0] st_hi;
    logic             black;
    logic             gray;
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] base;
    logic             neg;
    logic [NumW-1:0]  num_sat;
    logic [NumW-1:0]  num_hue;
    logic [ChanW-1:0] d;
  } s3_t;

  typedef struct packed {
    logic             dir;
    logic             zero_sat;
    logic [ChanW-1:0] v;
    logic [2:0]       region;
    logic [ChanW-1:0] p;
    logic [NumW-1:0]  qprod;
    logic [NumW-1:0]  tprod;
    logic             black;
    logic             gray;
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] base;
    logic             neg;
  } s4_t;

  typedef struct packed {
    logic             dir;
    pix_out_t         rgb;
    logic             black;
    logic             gray;
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] base;
    logic             neg;
  } tail_t;

  logic              dir_q;
  logic [Stages:1]   vld_q, vld_d;
  logic [Stages+1:1] en;

  s1_t      s1_q, s1_d;
  s2_t      s2_q, s2_d;
  s3_t      s3_q, s3_d;
  s4_t      s4_q, s4_d;
  tail_t    s5_q, s5_d, s6_q, s7_q;
  pix_out_t out_q, out_d;
  logic     out_dir_q;

  logic [QuoW-1:0] sat_quo, hue_quo;

  // direction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DirHsvToRgb;
    end else if (cfg_we_i) begin
      dir_q <= cfg_data_i;
    end
  end

  // stage advance chain
  assign en[Stages+1] = ~out_stall_i;
  for (genvar k = 1; k <= Stages; k++) begin : g_en
    assign en[k] = ~vld_q[k] | en[k+1];
  end
  assign in_stall_o = ~en[1];

  always_comb begin
    vld_d = vld_q;
    if (en[1]) begin
      vld_d[1] = in_valid_i;
    end
    for (int k = 2; k <= Stages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: input register
  always_comb begin
    s1_d.dir = dir_q;
    s1_d.pix = in_data_i;
  end

  // stage 2: hue sector, max/min and difference
  always_comb begin
    logic [ChanW-1:0] h, r, g, b, sub, mn;
    h = s1_q.pix.comp_first;
    r = s1_q.pix.comp_first;
    g = s1_q.pix.comp_second;
    b = s1_q.pix.comp_third;

    s2_d.dir      = s1_q.dir;
    s2_d.v        = s1_q.pix.comp_third;
    s2_d.s        = s1_q.pix.comp_second;
    s2_d.zero_sat = (s1_q.pix.comp_second == '0);

    priority if (h >= ChanW'(5 * HueSpan)) begin
      s2_d.region = Sector5;
      sub = ChanW'(5 * HueSpan);
    end else if (h >= ChanW'(4 * HueSpan)) begin
      s2_d.region = Sector4;
      sub = ChanW'(4 * HueSpan);
    end else if (h >= ChanW'(3 * HueSpan)) begin
      s2_d.region = Sector3;
      sub = ChanW'(3 * HueSpan);
    end else if (h >= ChanW'(2 * HueSpan)) begin
      s2_d.region = Sector2;
      sub = ChanW'(2 * HueSpan);
    end else if (h >= HueSpan) begin
      s2_d.region = Sector1;
      sub = HueSpan;
    end else begin
      s2_d.region = Sector0;
      sub = '0;
    end
    s2_d.rem6 = ChanW'((10'(h - sub)) * 10'd6);

    mn = (r < g) ? r : g;
    if (b < mn) begin
      mn = b;
    end

    priority if (r >= g && r >= b) begin
      s2_d.mx   = r;
      s2_d.base = HueBaseRed;
      s2_d.neg  = (g < b);
      s2_d.mag  = (g < b) ? (b - g) : (g - b);
    end else if (g >= b) begin
      s2_d.mx   = g;
      s2_d.base = HueBaseGreen;
      s2_d.neg  = (b < r);
      s2_d.mag  = (b < r) ? (r - b) : (b - r);
    end else begin
      s2_d.mx   = b;
      s2_d.base = HueBaseBlue;
      s2_d.neg  = (r < g);
      s2_d.mag  = (r < g) ? (g - r) : (r - g);
    end

    s2_d.d     = s2_d.mx - mn;
    s2_d.black = (s2_d.mx == '0);
    s2_d.gray  = (s2_d.mx == mn);
  end

  // stage 3: shade products and divider numerators
  always_comb begin
    logic [NumW-1:0] sr, st, pp;
    pp = NumW'(s2_q.v) * NumW'(ChanMax - s2_q.s);
    sr = NumW'(s2_q.s) * NumW'(s2_q.rem6);
    st = NumW'(s2_q.s) * NumW'(ChanMax - s2_q.rem6);

    s3_d.dir      = s2_q.dir;
    s3_d.zero_sat = s2_q.zero_sat;
    s3_d.v        = s2_q.v;
    s3_d.region   = s2_q.region;
    s3_d.p        = pp[NumW-1:ChanW];
    s3_d.sr_hi    = sr[NumW-1:ChanW];
    s3_d.st_hi    = st[NumW-1:ChanW];
    s3_d.black    = s2_q.black;
    s3_d.gray     = s2_q.gray;
    s3_d.mx       = s2_q.mx;
    s3_d.base     = s2_q.base;
    s3_d.neg      = s2_q.neg;
    s3_d.num_sat  = {s2_q.d, ChanW'(0)} - NumW'(s2_q.d);
    s3_d.num_hue  = NumW'(s2_q.mag) * NumW'(HueSpan);
    s3_d.d        = s2_q.d;
  end

  // stage 4: q and t products
  always_comb begin
    s4_d.dir      = s3_q.dir;
    s4_d.zero_sat = s3_q.zero_sat;
    s4_d.v        = s3_q.v;
    s4_d.region   = s3_q.region;
    s4_d.p        = s3_q.p;
    s4_d.qprod    = NumW'(s3_q.v) * NumW'(ChanMax - s3_q.sr_hi);
    s4_d.tprod    = NumW'(s3_q.v) * NumW'(ChanMax - s3_q.st_hi);
    s4_d.black    = s3_q.black;
    s4_d.gray     = s3_q.gray;
    s4_d.mx       = s3_q.mx;
    s4_d.base     = s3_q.base;
    s4_d.neg      = s3_q.neg;
  end

  // stage 5: sector mapping onto red, green, blue
  always_comb begin
    logic [ChanW-1:0] q, t, v, p;
    q = s4_q.qprod[NumW-1:ChanW];
    t = s4_q.tprod[NumW-1:ChanW];
    v = s4_q.v;
    p = s4_q.p;

    s5_d.dir   = s4_q.dir;
    s5_d.black = s4_q.black;
    s5_d.gray  = s4_q.gray;
    s5_d.mx    = s4_q.mx;
    s5_d.base  = s4_q.base;
    s5_d.neg   = s4_q.neg;

    if (s4_q.zero_sat) begin
      s5_d.rgb = '{res_first: v, res_second: v, res_third: v};
    end else begin
      unique case (s4_q.region)
        Sector0: s5_d.rgb = '{res_first: v, res_second: t, res_third: p};
        Sector1: s5_d.rgb = '{res_first: q, res_second: v, res_third: p};
        Sector2: s5_d.rgb = '{res_first: p, res_second: v, res_third: t};
        Sector3: s5_d.rgb = '{res_first: p, res_second: q, res_third: v};
        Sector4: s5_d.rgb = '{res_first: t, res_second: p, res_third: v};
        default: s5_d.rgb = '{res_first: v, res_second: p, res_third: q};
      endcase
    end
  end

  rhc_divider u_sat_div (
    .clk_i (clk_i),
    .en_i  (en[FrontStages+DivStages:FrontStages+1]),
    .num_i (s3_q.num_sat),
    .den_i (s3_q.mx),
    .quo_o (sat_quo)
  );

  rhc_divider u_hue_div (
    .clk_i (clk_i),
    .en_i  (en[FrontStages+DivStages:FrontStages+1]),
    .num_i (s3_q.num_hue),
    .den_i (s3_q.d),
    .quo_o (hue_quo)
  );

  // output stage: hue offset and result select
  always_comb begin
    if (s7_q.dir == DirHsvToRgb) begin
      out_d = s7_q.rgb;
    end else begin
      out_d.res_third  = s7_q.mx;
      out_d.res_second = s7_q.black ? '0 : sat_quo;
      if (s7_q.black || s7_q.gray) begin
        out_d.res_first = '0;
      end else if (s7_q.neg) begin
        out_d.res_first = s7_q.base - hue_quo;
      end else begin
        out_d.res_first = s7_q.base + hue_quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) s1_q <= s1_d;
    if (en[2]) s2_q <= s2_d;
    if (en[3]) s3_q <= s3_d;
    if (en[4]) s4_q <= s4_d;
    if (en[5]) s5_q <= s5_d;
    if (en[6]) s6_q <= s5_q;
    if (en[7]) s7_q <= s6_q;
    if (en[8]) begin
      out_q     <= out_d;
      out_dir_q <= s7_q.dir;
    end
  end

  assign out_valid_o = vld_q[Stages];
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled while a pipeline stage is empty");

  a_black_has_no_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_dir_q == DirRgbToHsv && out_data_o.res_third == '0)
      |-> (out_data_o.res_first == '0 && out_data_o.res_second == '0))
    else $error("black pixel with nonzero hue or saturation");

  a_gray_has_no_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_dir_q == DirRgbToHsv && out_data_o.res_second == '0)
      |-> (out_data_o.res_first == '0))
    else $error("zero saturation with nonzero hue");
`endif

endmodule
